// ===== design/fslot_pkg.sv =====
`timescale 1ns / 1ps
package fslot_pkg;

	localparam int SLOTS  = 256;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int SLOT_W = 9;
	localparam int CHG_W  = 32;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TOP_RD,
		ST_TOP
	} fslot_state_t;

	// stack memory access from the sequencer
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] wr_data;
	} stk_req_t;

endpackage

// ===== design/fslot_stack.sv =====
`timescale 1ns / 1ps
module fslot_stack
	import fslot_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  stk_req_t         req,
	output logic [IDX_W-1:0] rd_data
);

	logic [IDX_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [IDX_W-1:0] mem_rd_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic             rd_vld_q;

	// entries never written read back as their own index (reset contents)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_q  <= mem[req.rd_addr];
			rd_vld_q  <= vld_q[req.rd_addr];
			rd_addr_q <= req.rd_addr;
		end
	end

	assign rd_data = rd_vld_q ? mem_rd_q : rd_addr_q;

endmodule

// ===== design/fslot_ctrl.sv =====
`timescale 1ns / 1ps
module fslot_ctrl
	import fslot_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              action,
	input  logic [SLOT_W-1:0] slot,
	input  logic              cfg_we,
	input  logic              cfg_data,
	input  logic [IDX_W-1:0]  rd_data,
	output stk_req_t          req,
	output logic              busy,
	output logic              done,
	output logic [SLOT_W-1:0] granted_slot,
	output logic              accepted,
	output logic [CHG_W-1:0]  change_count
);

	fslot_state_t      state_q, state_d;
	logic              dup_chk_q;
	logic [CNT_W-1:0]  count_q;
	logic [CHG_W-1:0]  chg_q;
	logic              done_q;
	logic              action_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pend_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  pos_q;
	logic [SLOT_W-1:0] granted_q;
	logic              acc_q;

	logic              latch, scan_issue, go_found, fin, fin_ok, cnt_up, cnt_dn, hit;
	logic [SLOT_W-1:0] fin_slot;
	logic [CNT_W-1:0]  top;
	logic [IDX_W-1:0]  top_idx;

	// shared compare: one stack entry against the wanted slot per cycle
	assign hit     = pend_q && (rd_data == slot_q[IDX_W-1:0]);
	assign top     = count_q - CNT_W'(1);
	assign top_idx = top[IDX_W-1:0];

	always_comb begin
		state_d    = state_q;
		req        = '0;
		latch      = 1'b0;
		scan_issue = 1'b0;
		go_found   = 1'b0;
		fin        = 1'b0;
		fin_ok     = 1'b0;
		fin_slot   = slot_q;
		cnt_up     = 1'b0;
		cnt_dn     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					latch = 1'b1;
					if (action == ACT_ALLOC) begin
						if (count_q == '0) begin
							fin      = 1'b1;
							fin_slot = SLOT_W'(SLOTS);
						end else if (slot < SLOT_W'(SLOTS)) begin
							state_d = ST_SCAN;
						end else begin
							state_d = ST_TOP_RD;
						end
					end else begin
						fin_slot = slot;
						if (slot >= SLOT_W'(SLOTS) || count_q == CNT_W'(SLOTS)) begin
							fin = 1'b1;
						end else if (dup_chk_q) begin
							state_d = ST_SCAN;
						end else begin
							req.wr_en   = 1'b1;
							req.wr_addr = count_q[IDX_W-1:0];
							req.wr_data = slot[IDX_W-1:0];
							fin         = 1'b1;
							fin_ok      = 1'b1;
							cnt_up      = 1'b1;
						end
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					if (action_q == ACT_ALLOC) begin
						go_found = 1'b1;
						state_d  = ST_TOP_RD;
					end else begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (idx_q != count_q) begin
					scan_issue  = 1'b1;
					req.rd_en   = 1'b1;
					req.rd_addr = idx_q[IDX_W-1:0];
				end else if (action_q == ACT_ALLOC) begin
					state_d = ST_TOP_RD;
				end else begin
					req.wr_en   = 1'b1;
					req.wr_addr = count_q[IDX_W-1:0];
					req.wr_data = slot_q[IDX_W-1:0];
					fin         = 1'b1;
					fin_ok      = 1'b1;
					cnt_up      = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_TOP_RD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = top_idx;
				state_d     = ST_TOP;
			end
			ST_TOP: begin
				if (found_q) begin
					fin_slot = slot_q;
					// wanted slot below the top: old top moves into its place
					if (pos_q != top_idx) begin
						req.wr_en   = 1'b1;
						req.wr_addr = pos_q;
						req.wr_data = rd_data;
					end
				end else begin
					fin_slot = SLOT_W'(rd_data);
				end
				fin     = 1'b1;
				fin_ok  = 1'b1;
				cnt_dn  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dup_chk_q <= 1'b0;
			count_q   <= CNT_W'(SLOTS);
			chg_q     <= CHG_W'(SLOTS);
			done_q    <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			pend_q  <= scan_issue;
			if (cfg_we) begin
				dup_chk_q <= cfg_data;
			end
			if (cnt_up) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dn) begin
				count_q <= top;
			end
			if (cnt_up || cnt_dn) begin
				chg_q <= chg_q + CHG_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch) begin
			action_q <= action;
			slot_q   <= slot;
			idx_q    <= '0;
			found_q  <= 1'b0;
		end else if (scan_issue) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (scan_issue) begin
			pend_idx_q <= idx_q[IDX_W-1:0];
		end
		if (go_found) begin
			found_q <= 1'b1;
			pos_q   <= pend_idx_q;
		end
		if (fin) begin
			granted_q <= fin_slot;
			acc_q     <= fin_ok;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign granted_slot = granted_q;
	assign accepted     = acc_q;
	assign change_count = chg_q;

endmodule

// ===== design/free_slot_stack_allocator.sv =====
`timescale 1ns / 1ps
// A free without duplicate check or a request rejected on entry finishes straight from
// idle; an allocate of any slot reads the stack top (ST_TOP_RD, then ST_TOP); a targeted
// allocate first scans up to N entries and a checked free scans them too, N being the
// free count (one stack word compared per cycle through the single read port). One
// request at a time: busy drops as done rises, and a new request is taken from then on. Results cannot be stalled.
// Async reset: stack holds slot i at entry i, all free, change count at 256.
module free_slot_stack_allocator
	import fslot_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [SLOT_W-1:0] slot,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	output logic              done,
	output logic [SLOT_W-1:0] granted_slot,
	output logic              accepted,
	output logic [CHG_W-1:0]  change_count
);

	stk_req_t         req;
	logic [IDX_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	fslot_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.slot         (slot),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.rd_data      (rd_data),
		.req          (req),
		.busy         (busy),
		.done         (done),
		.granted_slot (granted_slot),
		.accepted     (accepted),
		.change_count (change_count)
	);

	fslot_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule

// ===== design/fslot_chk.sv =====
`timescale 1ns / 1ps
module fslot_chk
	import fslot_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [SLOT_W-1:0] granted_slot,
	input logic              accepted,
	input logic [CHG_W-1:0]  change_count
);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted word neither in progress nor finished");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> granted_slot < SLOT_W'(SLOTS))
		else $error("accepted result with out of range slot");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> change_count == $past(change_count) + CHG_W'(1))
		else $error("change count did not step on success");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && !accepted |-> $stable(change_count))
		else $error("change count moved on rejected request");

endmodule

bind free_slot_stack_allocator fslot_chk u_fslot_chk (.*);
